/* rtl/sc3dh_pkg.sv */
package sc3dh_pkg;

  localparam int COORD_W      = 12;
  localparam int DIFF_W       = COORD_W + 1;
  localparam int FRAC_BITS    = 31 - COORD_W;
  localparam int CORDIC_W     = 36;
  localparam int ANGLE_W      = 20;
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);

  localparam int MAX_RADIAL_BINS    = 8;
  localparam int MAX_AZIMUTH_BINS   = 16;
  localparam int MAX_ELEVATION_BINS = 8;
  localparam int STORE_DEPTH        = MAX_RADIAL_BINS * MAX_AZIMUTH_BINS * MAX_ELEVATION_BINS;
  localparam int ADDR_W             = $clog2(STORE_DEPTH);
  localparam int COUNT_W            = 16;
  localparam int TOTAL_W            = 24;
  localparam int FRAC_W             = 17;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  localparam logic signed [ANGLE_W:0] PI_Q16      = 21'sd205887;
  localparam logic signed [ANGLE_W:0] HALF_PI_Q16 = 21'sd102944;
  localparam logic [23:0]             AZ_SPAN_Q16 = 24'd418328;
  localparam logic [23:0]             EL_SPAN_Q16 = 24'd212441;

  localparam logic [1:0] KIND_ADD   = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  localparam logic [2:0] REG_CENTER_X  = 3'd0;
  localparam logic [2:0] REG_CENTER_Y  = 3'd1;
  localparam logic [2:0] REG_CENTER_Z  = 3'd2;
  localparam logic [2:0] REG_RADIAL    = 3'd3;
  localparam logic [2:0] REG_AZIMUTH   = 3'd4;
  localparam logic [2:0] REG_ELEVATION = 3'd5;
  localparam logic [2:0] REG_RADIUS    = 3'd6;

  // arctangent of 2^-i in Q16 radians
  function automatic logic signed [ANGLE_W-1:0] atan_q16(input logic [STEP_W-1:0] i);
    logic signed [ANGLE_W-1:0] v;
    unique case (i)
      4'd0:  v = 20'sd51472;
      4'd1:  v = 20'sd30386;
      4'd2:  v = 20'sd16055;
      4'd3:  v = 20'sd8150;
      4'd4:  v = 20'sd4091;
      4'd5:  v = 20'sd2047;
      4'd6:  v = 20'sd1024;
      4'd7:  v = 20'sd512;
      4'd8:  v = 20'sd256;
      4'd9:  v = 20'sd128;
      4'd10: v = 20'sd64;
      4'd11: v = 20'sd32;
      4'd12: v = 20'sd16;
      4'd13: v = 20'sd8;
      4'd14: v = 20'sd4;
      default: v = 20'sd2;
    endcase
    return v;
  endfunction

endpackage

/* rtl/shape_context_3d_histogram.sv */
// Spherical shape-context histogram. An add transaction offsets the point by the
// configured centre and bins it by radius, azimuth and elevation into a store of
// 1024 saturating 16-bit counters; a read transaction returns one bin; a clear
// transaction zeroes the store and the total. Every transaction gives exactly one
// result with the bin indices, the bin count, count/total in Q1.16 and the total.
// Work runs under one sequencer around a shared multiplier, an iterative CORDIC
// (16 steps per angle), a bit-serial square root and a restoring divider. An add
// runs the radius search, the azimuth CORDIC pass, the square root, the elevation
// CORDIC pass, the angle bin searches and the divide; for a point at the centre
// both CORDIC passes see a zero vector and skip their rotation steps. A read
// skips the divide when the total is zero, and a no-op goes straight to its
// result. A clear and reset each run a clearing pass over the store, one entry
// per cycle, with in_stall high; configuration writes are taken throughout. A
// finished result waits in the output register while the next transaction is
// accepted; a result that finds the output register still full holds the block.
module shape_context_3d_histogram import sc3dh_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           kind,
  input  logic signed [11:0]   px,
  input  logic signed [11:0]   py,
  input  logic signed [11:0]   pz,
  input  logic [2:0]           read_radial,
  input  logic [3:0]           read_azimuth,
  input  logic [2:0]           read_elevation,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           radial_index,
  output logic [3:0]           azimuth_index,
  output logic [2:0]           elevation_index,
  output logic [COUNT_W-1:0]   bin_count,
  output logic [FRAC_W-1:0]    bin_fraction,
  output logic [TOTAL_W-1:0]   total_points,
  input  logic                 cfg_write,
  input  logic [2:0]           cfg_index,
  input  logic [11:0]          cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE, S_CLR, S_SQX, S_SQY, S_SQZ, S_R2, S_RN1, S_RN2, S_RN3,
    S_RS1, S_RS2, S_AZS, S_AZW, S_SQRT, S_ELS, S_ELW,
    S_AMUL, S_ALD, S_ASTEP, S_RD, S_UPD, S_DIV, S_FIN
  } state_t;

  state_t state;

  // configuration
  logic signed [11:0] center_x, center_y, center_z;
  logic [3:0]  radial_bins, elevation_bins;
  logic [4:0]  azimuth_bins;
  logic [11:0] radius_max;

  // effective settings
  logic [3:0]  nr, ne;
  logic [4:0]  na;
  logic [11:0] m;

  // per-transaction working registers
  logic signed [DIFF_W-1:0] dx, dy, dz;
  logic [DIFF_W-1:0]        ax, ay, az_abs;
  logic [25:0]              pl2, r2;
  logic [31:0]              rn;
  logic [14:0]              km;
  logic [4:0]               k;
  logic [2:0]               ri, ei;
  logic [3:0]               ai;
  logic                     op_add, asel, clr_reply;
  logic signed [ANGLE_W:0]  az_ang, el_ang;
  logic [23:0]              av, ks;

  // shared multiplier
  logic [31:0] mul_a;
  logic [15:0] mul_b;
  logic [47:0] prod;

  // square root
  logic [63:0] sq_rad;
  logic [33:0] sq_rem;
  logic [31:0] sq_root;
  logic [4:0]  sq_cnt;
  logic [35:0] sq_trial_rem, sq_trial;

  // divider
  logic [COUNT_W-1:0] cnt, cnt_new;
  logic [TOTAL_W-1:0] total, tot_new;
  logic [FRAC_W-1:0]  fq;
  logic [24:0]        drem;
  logic [4:0]         dstep;
  logic [25:0]        dshift;

  // angle bin search
  logic signed [ANGLE_W:0] ang_sel;
  logic [4:0]              n_sel;
  logic [23:0]             span_sel;
  logic                    a_last;

  // store
  logic [COUNT_W-1:0] mem [STORE_DEPTH];
  logic [COUNT_W-1:0] rdata;
  logic [ADDR_W-1:0]  clr_addr, bin_addr, waddr;
  logic [COUNT_W-1:0] wdata;
  logic               mem_we;

  // CORDIC
  logic                       cordic_start, cordic_done;
  logic signed [CORDIC_W-1:0] cx_in, cy_in;
  logic signed [ANGLE_W-1:0]  cordic_angle;

  sc3dh_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cordic_start),
    .x_in  (cx_in),
    .y_in  (cy_in),
    .done  (cordic_done),
    .angle (cordic_angle)
  );

  always_comb begin
    // out-of-range bin counts and a zero radius act as the nearest legal value
    nr = (radial_bins == '0) ? 4'd1 :
         (radial_bins > 4'(MAX_RADIAL_BINS)) ? 4'(MAX_RADIAL_BINS) : radial_bins;
    na = (azimuth_bins == '0) ? 5'd1 :
         (azimuth_bins > 5'(MAX_AZIMUTH_BINS)) ? 5'(MAX_AZIMUTH_BINS) : azimuth_bins;
    ne = (elevation_bins == '0) ? 4'd1 :
         (elevation_bins > 4'(MAX_ELEVATION_BINS)) ? 4'(MAX_ELEVATION_BINS) : elevation_bins;
    m  = (radius_max == '0) ? 12'd1 : radius_max;

    ax     = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
    ay     = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
    az_abs = dz[DIFF_W-1] ? DIFF_W'(-dz) : DIFF_W'(dz);

    ang_sel  = asel ? el_ang : az_ang;
    n_sel    = asel ? {1'b0, ne} : na;
    span_sel = asel ? EL_SPAN_Q16 : AZ_SPAN_Q16;
    a_last   = (k >= n_sel - 5'd1);

    sq_trial_rem = {sq_rem, sq_rad[63:62]};
    sq_trial     = {2'b00, sq_root, 2'b01};

    dshift = (dstep == '0) ? {1'b0, drem} : {drem, 1'b0};

    cnt_new = op_add ? ((rdata == COUNT_MAX) ? rdata : rdata + 1'b1) : rdata;
    tot_new = op_add ? ((total == TOTAL_MAX) ? total : total + 1'b1) : total;

    bin_addr = {ri, ai, ei};
    mem_we   = (state == S_CLR) || (state == S_UPD && op_add);
    waddr    = (state == S_CLR) ? clr_addr : bin_addr;
    wdata    = (state == S_CLR) ? '0 : cnt_new;

    cordic_start = (state == S_AZS) || (state == S_ELS);
    if (state == S_ELS) begin
      cx_in = CORDIC_W'(sq_root);
      cy_in = {{(CORDIC_W-DIFF_W-FRAC_BITS){dz[DIFF_W-1]}}, dz, {FRAC_BITS{1'b0}}};
    end else begin
      cx_in = {{(CORDIC_W-DIFF_W-FRAC_BITS){dx[DIFF_W-1]}}, dx, {FRAC_BITS{1'b0}}};
      cy_in = {{(CORDIC_W-DIFF_W-FRAC_BITS){dy[DIFF_W-1]}}, dy, {FRAC_BITS{1'b0}}};
    end

    unique case (state)
      S_SQX:   begin mul_a = 32'(ax);      mul_b = 16'(ax);     end
      S_SQY:   begin mul_a = 32'(ay);      mul_b = 16'(ay);     end
      S_SQZ:   begin mul_a = 32'(az_abs);  mul_b = 16'(az_abs); end
      S_RN1:   begin mul_a = 32'(r2);      mul_b = 16'(nr);     end
      S_RN2:   begin mul_a = prod[31:0];   mul_b = 16'(nr);     end
      S_RS1:   begin mul_a = 32'(km);      mul_b = 16'(km);     end
      S_AMUL:  begin
        // a non-positive angle lands in bin zero
        mul_a = (!ang_sel[ANGLE_W] && ang_sel != '0) ? 32'(ang_sel[ANGLE_W-1:0]) : '0;
        mul_b = 16'(n_sel);
      end
      default: begin mul_a = '0;           mul_b = '0;          end
    endcase
  end

  // store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[bin_addr];
  end

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLR;
      clr_addr       <= '0;
      clr_reply      <= 1'b0;
      total          <= '0;
      out_valid      <= 1'b0;
      asel           <= 1'b0;
      center_x       <= '0;
      center_y       <= '0;
      center_z       <= '0;
      radial_bins    <= 4'd3;
      azimuth_bins   <= 5'd8;
      elevation_bins <= 4'd4;
      radius_max     <= 12'd866;
    end else begin
      prod <= mul_a * mul_b;

      if (cfg_write) begin
        case (cfg_index)
          REG_CENTER_X:  center_x       <= cfg_data;
          REG_CENTER_Y:  center_y       <= cfg_data;
          REG_CENTER_Z:  center_z       <= cfg_data;
          REG_RADIAL:    radial_bins    <= cfg_data[3:0];
          REG_AZIMUTH:   azimuth_bins   <= cfg_data[4:0];
          REG_ELEVATION: elevation_bins <= cfg_data[3:0];
          REG_RADIUS:    radius_max     <= cfg_data;
          default: ;
        endcase
      end

      // load a finished result when the output register is free or drains
      // this cycle; otherwise drop the result once taken
      if (state == S_FIN && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            unique case (kind)
              KIND_ADD: begin
                dx     <= DIFF_W'(px) - DIFF_W'(center_x);
                dy     <= DIFF_W'(py) - DIFF_W'(center_y);
                dz     <= DIFF_W'(pz) - DIFF_W'(center_z);
                op_add <= 1'b1;
                ri     <= '0;
                state  <= S_SQX;
              end
              KIND_READ: begin
                ri     <= read_radial;
                ai     <= read_azimuth;
                ei     <= read_elevation;
                op_add <= 1'b0;
                state  <= S_RD;
              end
              KIND_CLEAR: begin
                total     <= '0;
                ri        <= '0;
                ai        <= '0;
                ei        <= '0;
                cnt       <= '0;
                fq        <= '0;
                clr_addr  <= '0;
                clr_reply <= 1'b1;
                state     <= S_CLR;
              end
              default: begin
                ri    <= '0;
                ai    <= '0;
                ei    <= '0;
                cnt   <= '0;
                fq    <= '0;
                state <= S_FIN;
              end
            endcase
          end
        end
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(STORE_DEPTH - 1)) begin
            state <= clr_reply ? S_FIN : S_IDLE;
          end
        end
        S_SQX: state <= S_SQY;
        S_SQY: begin
          pl2   <= prod[25:0];
          state <= S_SQZ;
        end
        S_SQZ: begin
          pl2   <= pl2 + prod[25:0];
          state <= S_R2;
        end
        S_R2: begin
          r2    <= pl2 + prod[25:0];
          state <= S_RN1;
        end
        S_RN1: state <= S_RN2;
        S_RN2: state <= S_RN3;
        S_RN3: begin
          rn    <= prod[31:0];
          km    <= 15'(m);
          k     <= 5'd1;
          state <= (nr == 4'd1) ? S_AZS : S_RS1;
        end
        S_RS1: state <= S_RS2;
        S_RS2: begin
          // (k*m)^2 <= r^2*nr^2 holds for a prefix of k; keep the last hit
          if (prod[31:0] <= rn) begin
            ri <= k[2:0];
          end
          km <= km + 15'(m);
          k  <= k + 1'b1;
          if (k == 5'(nr) - 5'd1) begin
            state <= S_AZS;
          end else begin
            state <= S_RS1;
          end
        end
        S_AZS: state <= S_AZW;
        S_AZW: begin
          if (cordic_done) begin
            az_ang  <= {cordic_angle[ANGLE_W-1], cordic_angle} + PI_Q16;
            sq_rad  <= {pl2, {(2*FRAC_BITS){1'b0}}};
            sq_rem  <= '0;
            sq_root <= '0;
            sq_cnt  <= '0;
            state   <= S_SQRT;
          end
        end
        S_SQRT: begin
          // two radicand bits in, one root bit out
          if (sq_trial_rem >= sq_trial) begin
            sq_rem  <= 34'(sq_trial_rem - sq_trial);
            sq_root <= {sq_root[30:0], 1'b1};
          end else begin
            sq_rem  <= sq_trial_rem[33:0];
            sq_root <= {sq_root[30:0], 1'b0};
          end
          sq_rad <= {sq_rad[61:0], 2'b00};
          sq_cnt <= sq_cnt + 1'b1;
          if (sq_cnt == 5'd31) begin
            state <= S_ELS;
          end
        end
        S_ELS: state <= S_ELW;
        S_ELW: begin
          if (cordic_done) begin
            el_ang <= {cordic_angle[ANGLE_W-1], cordic_angle} + HALF_PI_Q16;
            asel   <= 1'b0;
            state  <= S_AMUL;
          end
        end
        S_AMUL: state <= S_ALD;
        S_ALD: begin
          av <= prod[23:0];
          ks <= span_sel;
          k  <= 5'd1;
          if (asel) begin
            ei <= '0;
          end else begin
            ai <= '0;
          end
          if (n_sel == 5'd1) begin
            asel  <= 1'b1;
            state <= asel ? S_RD : S_AMUL;
          end else begin
            state <= S_ASTEP;
          end
        end
        S_ASTEP: begin
          // index = largest k below n with k*span <= angle*n
          if (ks <= av) begin
            if (asel) begin
              ei <= k[2:0];
            end else begin
              ai <= k[3:0];
            end
          end
          ks <= ks + span_sel;
          k  <= k + 1'b1;
          if (a_last) begin
            asel  <= 1'b1;
            state <= asel ? S_RD : S_AMUL;
          end
        end
        S_RD: state <= S_UPD;
        S_UPD: begin
          cnt   <= cnt_new;
          total <= tot_new;
          drem  <= 25'(cnt_new);
          fq    <= '0;
          dstep <= '0;
          state <= (tot_new == '0) ? S_FIN : S_DIV;
        end
        S_DIV: begin
          // restoring divide of count*2^16 by total; count never exceeds total
          if (dshift >= 26'(total)) begin
            drem <= 25'(dshift - 26'(total));
            fq   <= {fq[FRAC_W-2:0], 1'b1};
          end else begin
            drem <= dshift[24:0];
            fq   <= {fq[FRAC_W-2:0], 1'b0};
          end
          dstep <= dstep + 1'b1;
          if (dstep == 5'(FRAC_W - 1)) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          // hold until the output register is free or drains this cycle
          if (!out_valid || !out_stall) begin
            radial_index    <= ri;
            azimuth_index   <= ai;
            elevation_index <= ei;
            bin_count       <= cnt;
            bin_fraction    <= fq;
            total_points    <= total;
            clr_reply       <= 1'b0;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> bin_fraction <= FRAC_W'(65536))
    else $error("bin fraction above one");

  a_count_le_total: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> 24'(bin_count) <= total_points)
    else $error("bin count exceeds total");

  a_cordic_owner: assert property (@(posedge clk) disable iff (rst)
    cordic_done |-> (state == S_AZW || state == S_ELW))
    else $error("CORDIC finished outside an angle wait");

  a_clear_reply: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLR && clr_reply) |-> (total == '0 && cnt == '0))
    else $error("clear transaction left a nonzero result");

endmodule

/* rtl/sc3dh_cordic.sv */
module sc3dh_cordic import sc3dh_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic signed [CORDIC_W-1:0] x_in,
  input  logic signed [CORDIC_W-1:0] y_in,
  output logic                       done,
  output logic signed [ANGLE_W-1:0]  angle
);

  logic signed [CORDIC_W-1:0] x, y, ux, uy;
  logic signed [ANGLE_W-1:0]  at;
  logic [STEP_W-1:0]          step;
  logic                       busy;

  always_comb begin
    ux = y >>> step;
    uy = x >>> step;
    at = atan_q16(step);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      // pulse on a zero vector at start, or after the last rotation step
      done <= start ? (x_in == '0 && y_in == '0)
                    : (busy && step == STEP_W'(CORDIC_STEPS - 1));
      if (start) begin
        step <= '0;
        if (x_in == '0 && y_in == '0) begin
          // zero vector: angle zero, no rotation
          angle <= '0;
        end else begin
          busy <= 1'b1;
          if (x_in[CORDIC_W-1]) begin
            // left half plane: pre-rotate by a quarter turn
            if (!y_in[CORDIC_W-1]) begin
              x     <= y_in;
              y     <= -x_in;
              angle <= HALF_PI_Q16[ANGLE_W-1:0];
            end else begin
              x     <= -y_in;
              y     <= x_in;
              angle <= -HALF_PI_Q16[ANGLE_W-1:0];
            end
          end else begin
            x     <= x_in;
            y     <= y_in;
            angle <= '0;
          end
        end
      end else if (busy) begin
        if (!y[CORDIC_W-1]) begin
          x     <= x + ux;
          y     <= y - uy;
          angle <= angle + at;
        end else begin
          x     <= x - ux;
          y     <= y + uy;
          angle <= angle - at;
        end
        step <= step + 1'b1;
        if (step == STEP_W'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule
